[rtl/core/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque: sizes, command and
// status codes, and the per-item step information passed between modules.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_BITS  = $clog2(DEPTH);
  localparam int WORD_BITS = 32;
  localparam int CAP_BITS  = 5;
  localparam int ADDR_BITS = 3;

  localparam logic [CAP_BITS-1:0]  CAP_RESET = CAP_BITS'(16);
  localparam logic [WORD_BITS-1:0] WORD_MIN  = {1'b1, {(WORD_BITS-1){1'b0}}};

  // register index taken from paddr[2]
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    logic    pop_ok;
    logic    empty;
    logic    full;
  } step_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [IDX_BITS-1:0] addr;
  } mem_req_t;

endpackage

[rtl/core/cdq_ram.sv]
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/cdq_ptr.sv]
// ----------------------------------------------------------------------------
// cdq_ptr
// Index unit: holds front, rear and the empty mark, decides each command,
// issues the store access and reports status and flags after the step.
// ----------------------------------------------------------------------------
module cdq_ptr (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic [cdq_pkg::IDX_BITS-1:0] cap_last,
  input  logic                         accept,
  input  logic [1:0]                   command,
  output cdq_pkg::mem_req_t            mem_req,
  output cdq_pkg::step_t               step
);

  logic [cdq_pkg::IDX_BITS-1:0] front, front_next;
  logic [cdq_pkg::IDX_BITS-1:0] rear, rear_next;
  logic                         empty, empty_next;
  logic                         full_now;
  cdq_pkg::cmd_t                cmd;

  function automatic logic [cdq_pkg::IDX_BITS-1:0] idx_inc(
    input logic [cdq_pkg::IDX_BITS-1:0] i,
    input logic [cdq_pkg::IDX_BITS-1:0] last
  );
    return (i >= last) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [cdq_pkg::IDX_BITS-1:0] idx_dec(
    input logic [cdq_pkg::IDX_BITS-1:0] i,
    input logic [cdq_pkg::IDX_BITS-1:0] last
  );
    return (i == '0 || i > last) ? last : i - 1'b1;
  endfunction

  assign cmd      = cdq_pkg::cmd_t'(command);
  assign full_now = !empty && (idx_inc(rear, cap_last) == front);

  always_comb begin
    front_next   = front;
    rear_next    = rear;
    empty_next   = empty;
    mem_req.we   = 1'b0;
    mem_req.re   = 1'b0;
    mem_req.addr = front;
    step.status  = cdq_pkg::ST_OK;
    step.pop_ok  = 1'b0;
    case (cmd)
      cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
        if (full_now) begin
          step.status = cdq_pkg::ST_FULL;
        end else begin
          mem_req.we = accept;
          if (empty) begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b0;
            mem_req.addr = '0;
          end else if (cmd == cdq_pkg::CMD_PUSH_FRONT) begin
            front_next   = idx_dec(front, cap_last);
            mem_req.addr = front_next;
          end else begin
            rear_next    = idx_inc(rear, cap_last);
            mem_req.addr = rear_next;
          end
        end
      end
      default: begin
        if (empty) begin
          step.status = cdq_pkg::ST_EMPTY;
        end else begin
          step.pop_ok  = 1'b1;
          mem_req.re   = accept;
          mem_req.addr = (cmd == cdq_pkg::CMD_POP_FRONT) ? front : rear;
          if (front == rear) begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b1;
          end else if (cmd == cdq_pkg::CMD_POP_FRONT) begin
            front_next = idx_inc(front, cap_last);
          end else begin
            rear_next = idx_dec(rear, cap_last);
          end
        end
      end
    endcase
    step.empty = empty_next;
    step.full  = !empty_next && (idx_inc(rear_next, cap_last) == front_next);
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      front <= '0;
      rear  <= '0;
      empty <= 1'b1;
    end else if (accept) begin
      front <= front_next;
      rear  <= rear_next;
      empty <= empty_next;
    end
  end

endmodule

[rtl/core/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of signed words in a circular 16-entry store.
// ----------------------------------------------------------------------------
// Usage:
//   command channel (cmd_valid / cmd_stall): one word carries a command
//   (push front, push back, pop front, pop back) and the word to push.
//   response channel (rsp_valid / rsp_stall): one word per command with
//   status, popped value, and the empty and full flags after the command.
//   On the way to rsp_valid the command is decided and the store accessed
//   in the cycle it is accepted, the store's registered read is captured
//   in a holding stage, and the response register is loaded from there.
//   Throughput is one word per cycle while rsp_stall is low; the store's
//   single read port and the one-entry holding stage set that figure.
//   The capacity register (APB, byte address 0) sets how many entries take
//   part; writing it empties the deque. Write only while no command is open.
//   Reset empties the deque and sets capacity 16; the store itself is not
//   cleared, since only pushed entries are ever read.
//   While rsp_stall is high the response holds; one more command is taken
//   into the holding stage, then cmd_stall rises.
// ----------------------------------------------------------------------------
module circular_deque_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_stall,
  input  logic [1:0]                          command,
  input  logic signed [cdq_pkg::WORD_BITS-1:0] push_value,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [1:0]                          status,
  output logic signed [cdq_pkg::WORD_BITS-1:0] popped_value,
  output logic                                empty_flag,
  output logic                                full_flag,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cdq_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic [cdq_pkg::CAP_BITS-1:0] capacity_in_use;
  logic [cdq_pkg::IDX_BITS-1:0] cap_last;
  logic [cdq_pkg::CAP_BITS-1:0] cap_raw;
  logic                         cfg_write;
  logic                         accept;
  logic                         hold_valid, hold_move;
  cdq_pkg::step_t               step, hold_step;
  cdq_pkg::mem_req_t            mem_req;
  logic [cdq_pkg::WORD_BITS-1:0] rdata;
  logic [cdq_pkg::WORD_BITS-1:0] result_word;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == cdq_pkg::REG_CAPACITY);
  assign prdata    = (paddr[2] == cdq_pkg::REG_CAPACITY) ? 32'(capacity_in_use) : '0;
  assign cap_raw   = pwdata[cdq_pkg::CAP_BITS-1:0];

  // capacity stored raw for readback, plus the clamped last index
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= cdq_pkg::CAP_RESET;
      cap_last        <= cdq_pkg::IDX_BITS'(cdq_pkg::DEPTH - 1);
    end else if (cfg_write) begin
      capacity_in_use <= cap_raw;
      if (cap_raw == '0) begin
        cap_last <= '0;
      end else if (cap_raw > cdq_pkg::CAP_BITS'(cdq_pkg::DEPTH)) begin
        cap_last <= cdq_pkg::IDX_BITS'(cdq_pkg::DEPTH - 1);
      end else begin
        cap_last <= cdq_pkg::IDX_BITS'(cap_raw - 1'b1);
      end
    end
  end

  assign hold_move = hold_valid && (!rsp_valid || !rsp_stall);
  assign cmd_stall = hold_valid && !hold_move;
  assign accept    = cmd_valid && !cmd_stall;

  cdq_ptr u_ptr (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_write),
    .cap_last (cap_last),
    .accept   (accept),
    .command  (command),
    .mem_req  (mem_req),
    .step     (step)
  );

  // read data stays put while a pop waits in the holding stage: no new read
  cdq_ram #(
    .WIDTH (cdq_pkg::WORD_BITS),
    .DEPTH (cdq_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.addr),
    .wdata (push_value),
    .re    (mem_req.re),
    .raddr (mem_req.addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (hold_move) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_step <= step;
    end
  end

  always_comb begin
    if (hold_step.pop_ok) begin
      result_word = rdata;
    end else if (hold_step.status == cdq_pkg::ST_EMPTY) begin
      result_word = cdq_pkg::WORD_MIN;
    end else begin
      result_word = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (hold_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_move) begin
      status       <= hold_step.status;
      popped_value <= result_word;
      empty_flag   <= hold_step.empty;
      full_flag    <= hold_step.full;
    end
  end

endmodule

[rtl/core/cdq_checker.sv]
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks of the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                rsp_valid,
  input logic                                rsp_stall,
  input logic [1:0]                          status,
  input logic signed [cdq_pkg::WORD_BITS-1:0] popped_value,
  input logic                                empty_flag,
  input logic                                full_flag
);

  // a response never survives reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

  // failed pop carries the most negative word and leaves the deque empty
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == cdq_pkg::ST_EMPTY) |->
      (popped_value == cdq_pkg::WORD_MIN && empty_flag && !full_flag))
    else $error("empty pop response inconsistent");

  // dropped push reports a full deque and a zero word
  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == cdq_pkg::ST_FULL) |->
      (full_flag && !empty_flag && popped_value == '0))
    else $error("full push response inconsistent");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(empty_flag && full_flag))
    else $error("empty and full both set");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(popped_value) && $stable(status)))
    else $error("stalled response changed");

endmodule

bind circular_deque_unit cdq_checker u_cdq_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp_valid),
  .rsp_stall    (rsp_stall),
  .status       (status),
  .popped_value (popped_value),
  .empty_flag   (empty_flag),
  .full_flag    (full_flag)
);
